// File: hw/rtl/blinn_phong_shading_terms_defines.svh
// ----------------------------------------------------------------------------
// Blinn-Phong shading terms: assertion macros
// Shared concurrent checks, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef BLINN_PHONG_SHADING_TERMS_DEFINES_SVH
`define BLINN_PHONG_SHADING_TERMS_DEFINES_SVH

// Same-cycle implication.
`define BPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("blinn_phong_shading_terms: check failed");

// Next-cycle implication.
`define BPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("blinn_phong_shading_terms: check failed");

`endif

// File: hw/rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// Blinn-Phong shading terms: package
// Shared types, register indexes and the Q1.15 colour product.
// ----------------------------------------------------------------------------
package bps_pkg;

  typedef logic [15:0] q15_t;

  localparam q15_t Q15_ONE = 16'h8000;

  typedef struct packed {
    q15_t red;
    q15_t green;
    q15_t blue;
  } rgb_t;

  // Control bits that travel with each sample.
  typedef struct packed {
    logic valid;
    logic len_zero;
    logic dot_pos;
  } stage_ctl_t;

  localparam logic [2:0] REG_BASE_RED      = 3'd0;
  localparam logic [2:0] REG_BASE_GREEN    = 3'd1;
  localparam logic [2:0] REG_BASE_BLUE     = 3'd2;
  localparam logic [2:0] REG_SPEC_RED      = 3'd3;
  localparam logic [2:0] REG_SPEC_GREEN    = 3'd4;
  localparam logic [2:0] REG_SPEC_BLUE     = 3'd5;
  localparam logic [2:0] REG_SHININESS     = 3'd6;
  localparam logic [2:0] REG_COS_THRESHOLD = 3'd7;

  // (a*b) >> 15, truncated, then saturated to 1.0.
  function automatic q15_t mul_sat(input q15_t a, input q15_t b);
    logic [31:0] prod;
    logic [16:0] shr;
    prod = a * b;
    shr  = prod[31:15];
    return (shr > 17'(Q15_ONE)) ? Q15_ONE : shr[15:0];
  endfunction

endpackage

// File: hw/rtl/bps_front.sv
// ----------------------------------------------------------------------------
// Blinn-Phong shading terms: front end
// Dot products, half-vector length, diffuse cosine and colour, and the
// operands of the normalization search. Four register stages.
// ----------------------------------------------------------------------------
module bps_front #(
  parameter int VECTOR_FRAC_BITS = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [15:0]  light_x,
  input  logic signed [15:0]  light_y,
  input  logic signed [15:0]  light_z,
  input  logic signed [15:0]  normal_x,
  input  logic signed [15:0]  normal_y,
  input  logic signed [15:0]  normal_z,
  input  logic signed [15:0]  view_x,
  input  logic signed [15:0]  view_y,
  input  logic signed [15:0]  view_z,
  input  bps_pkg::rgb_t       base_col,
  input  bps_pkg::q15_t       cos_threshold,
  output bps_pkg::stage_ctl_t ctl,
  output bps_pkg::rgb_t       diffuse,
  output logic [70 + ((2*VECTOR_FRAC_BITS > 30) ? 2*VECTOR_FRAC_BITS - 30
                       : 30 - 2*VECTOR_FRAC_BITS) - 1:0] r_val,
  output logic [70 + ((2*VECTOR_FRAC_BITS > 30) ? 2*VECTOR_FRAC_BITS - 30
                       : 30 - 2*VECTOR_FRAC_BITS) - 1:0] l_val
);

  localparam int SHL_L = (2*VECTOR_FRAC_BITS > 30) ? 2*VECTOR_FRAC_BITS - 30 : 0;
  localparam int SHL_R = (2*VECTOR_FRAC_BITS > 30) ? 0 : 30 - 2*VECTOR_FRAC_BITS;
  localparam int CW    = 70 + SHL_L + SHL_R;
  localparam int DOWN  = 2*VECTOR_FRAC_BITS - 15;

  logic signed [15:0] w [3];
  logic signed [15:0] n [3];
  logic signed [15:0] v [3];
  logic signed [16:0] hv [3];

  logic               s1_valid;
  logic signed [31:0] s1_wn [3];
  logic signed [32:0] s1_nh [3];
  logic        [32:0] s1_hh [3];

  logic               s2_valid;
  logic signed [33:0] s2_doti;
  logic signed [33:0] s2_doth;
  logic        [33:0] s2_len;

  logic               s3_valid;
  bps_pkg::q15_t      s3_cosi;
  logic        [33:0] s3_aa;
  logic        [32:0] s3_ab;
  logic        [31:0] s3_bb;
  logic        [33:0] s3_len;
  logic               s3_dpos;

  logic        [33:0] doti_shr;
  bps_pkg::q15_t      cos_pre;
  bps_pkg::q15_t      cos_fin;
  logic        [32:0] dh_u;

  assign w = '{light_x, light_y, light_z};
  assign n = '{normal_x, normal_y, normal_z};
  assign v = '{view_x, view_y, view_z};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hv[k] = {v[k][15], v[k]} - {w[k][15], w[k]};
    end
  end

  always_comb begin
    doti_shr = s2_doti[33] ? '0 : (34'(s2_doti) >> DOWN);
    if (s2_doti[33] || s2_doti == '0) begin
      cos_pre = '0;
    end else if (doti_shr > 34'(bps_pkg::Q15_ONE)) begin
      cos_pre = bps_pkg::Q15_ONE;
    end else begin
      cos_pre = doti_shr[15:0];
    end
    // back-facing or grazing light counts as full
    cos_fin = (s2_doti[33] || cos_pre < cos_threshold) ? bps_pkg::Q15_ONE : cos_pre;
    dh_u    = s2_doth[32:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      ctl      <= '0;
    end else if (en) begin
      s1_valid     <= in_valid;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      ctl.valid    <= s3_valid;
      ctl.len_zero <= (s3_len == '0);
      ctl.dot_pos  <= s3_dpos;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_wn[k] <= w[k] * n[k];
        s1_nh[k] <= n[k] * hv[k];
        s1_hh[k] <= 33'(hv[k] * hv[k]);
      end
      s2_doti <= -(34'(s1_wn[0]) + 34'(s1_wn[1]) + 34'(s1_wn[2]));
      s2_doth <= 34'(s1_nh[0]) + 34'(s1_nh[1]) + 34'(s1_nh[2]);
      s2_len  <= 34'(s1_hh[0]) + 34'(s1_hh[1]) + 34'(s1_hh[2]);

      s3_cosi <= cos_fin;
      s3_aa   <= dh_u[32:16] * dh_u[32:16];
      s3_ab   <= dh_u[32:16] * dh_u[15:0];
      s3_bb   <= dh_u[15:0] * dh_u[15:0];
      s3_len  <= s2_len;
      s3_dpos <= !s2_doth[33] && (s2_doth != '0);

      diffuse.red   <= bps_pkg::mul_sat(s3_cosi, base_col.red);
      diffuse.green <= bps_pkg::mul_sat(s3_cosi, base_col.green);
      diffuse.blue  <= bps_pkg::mul_sat(s3_cosi, base_col.blue);
      // dot_h^2 rebuilt from the split halves
      r_val <= ((CW'(s3_aa) << 32) + (CW'(s3_ab) << 17) + CW'(s3_bb)) << SHL_R;
      l_val <= CW'(s3_len) << SHL_L;
    end
  end

endmodule

// File: hw/rtl/bps_norm.sv
// ----------------------------------------------------------------------------
// Blinn-Phong shading terms: half-vector normalization
// Restoring search for the largest c with c^2 * L <= R, one bit a stage,
// sixteen stages. Carries c*L so each stage needs only shifts, adds and a compare.
// ----------------------------------------------------------------------------
module bps_norm #(
  parameter int VECTOR_FRAC_BITS = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  bps_pkg::stage_ctl_t in_ctl,
  input  bps_pkg::rgb_t       in_diffuse,
  input  logic [70 + ((2*VECTOR_FRAC_BITS > 30) ? 2*VECTOR_FRAC_BITS - 30
                      : 30 - 2*VECTOR_FRAC_BITS) - 1:0] r_val,
  input  logic [70 + ((2*VECTOR_FRAC_BITS > 30) ? 2*VECTOR_FRAC_BITS - 30
                      : 30 - 2*VECTOR_FRAC_BITS) - 1:0] l_val,
  output bps_pkg::stage_ctl_t out_ctl,
  output bps_pkg::rgb_t       out_diffuse,
  output logic [15:0]         cos_raw
);

  localparam int SHL_L = (2*VECTOR_FRAC_BITS > 30) ? 2*VECTOR_FRAC_BITS - 30 : 0;
  localparam int SHL_R = (2*VECTOR_FRAC_BITS > 30) ? 0 : 30 - 2*VECTOR_FRAC_BITS;
  localparam int CW    = 70 + SHL_L + SHL_R;
  localparam int NB    = 16;

  logic [CW-1:0]       rem [NB];
  logic [CW-1:0]       pl  [NB];
  logic [CW-1:0]       lv  [NB];
  logic [NB-1:0]       cv  [NB+1];
  bps_pkg::stage_ctl_t ctl [NB+1];
  bps_pkg::rgb_t       dif [NB+1];

  assign rem[0] = r_val;
  assign pl[0]  = '0;
  assign lv[0]  = l_val;
  assign cv[0]  = '0;
  assign ctl[0] = in_ctl;
  assign dif[0] = in_diffuse;

  for (genvar i = 0; i < NB; i++) begin : g_step
    localparam int J = NB - 1 - i;
    logic [CW-1:0] term;
    logic          take;

    always_comb begin
      term = (pl[i] << (J + 1)) + (lv[i] << (2 * J));
      take = (term <= rem[i]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[i+1] <= '0;
      end else if (en) begin
        ctl[i+1] <= ctl[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dif[i+1] <= dif[i];
        cv[i+1]  <= cv[i] | (take ? (NB'(1) << J) : '0);
      end
    end

    if (i < NB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1] <= take ? rem[i] - term : rem[i];
          pl[i+1]  <= take ? pl[i] + (lv[i] << J) : pl[i];
          lv[i+1]  <= lv[i];
        end
      end
    end
  end

  assign out_ctl     = ctl[NB];
  assign out_diffuse = dif[NB];
  assign cos_raw     = cv[NB];

endmodule

// File: hw/rtl/bps_spec.sv
// ----------------------------------------------------------------------------
// Blinn-Phong shading terms: specular power and output register
// Clamp and threshold the half-vector cosine, raise it to the exponent by
// square and multiply over eight stages, scale by the specular colour.
// ----------------------------------------------------------------------------
module bps_spec (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  bps_pkg::stage_ctl_t in_ctl,
  input  bps_pkg::rgb_t       in_diffuse,
  input  logic [15:0]         cos_raw,
  input  logic [7:0]          shininess,
  input  bps_pkg::q15_t       cos_threshold,
  input  bps_pkg::rgb_t       spec_col,
  output logic                out_valid,
  output bps_pkg::rgb_t       diffuse,
  output bps_pkg::rgb_t       specular
);

  localparam int EB = 8;

  bps_pkg::q15_t       cos_clamp;
  bps_pkg::q15_t       cos_h;
  bps_pkg::q15_t       pw  [EB+1];
  bps_pkg::q15_t       bb  [EB];
  bps_pkg::stage_ctl_t ctl [EB+1];
  bps_pkg::rgb_t       dif [EB+1];

  always_comb begin
    cos_clamp = (cos_raw > bps_pkg::Q15_ONE) ? bps_pkg::Q15_ONE : cos_raw;
    cos_h     = (!in_ctl.dot_pos || cos_clamp < cos_threshold) ? '0 : cos_clamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else if (en) begin
      ctl[0] <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pw[0]  <= bps_pkg::Q15_ONE;
      bb[0]  <= cos_h;
      dif[0] <= in_diffuse;
    end
  end

  for (genvar i = 0; i < EB; i++) begin : g_pow
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[i+1] <= '0;
      end else if (en) begin
        ctl[i+1] <= ctl[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pw[i+1]  <= shininess[i] ? bps_pkg::mul_sat(pw[i], bb[i]) : pw[i];
        dif[i+1] <= dif[i];
      end
    end

    if (i < EB - 1) begin : g_sq
      always_ff @(posedge clk) begin
        if (en) begin
          bb[i+1] <= bps_pkg::mul_sat(bb[i], bb[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl[EB].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diffuse <= dif[EB];
      // zero-length half vector: no highlight
      specular.red   <= ctl[EB].len_zero ? '0 : bps_pkg::mul_sat(pw[EB], spec_col.red);
      specular.green <= ctl[EB].len_zero ? '0 : bps_pkg::mul_sat(pw[EB], spec_col.green);
      specular.blue  <= ctl[EB].len_zero ? '0 : bps_pkg::mul_sat(pw[EB], spec_col.blue);
    end
  end

endmodule

// File: hw/rtl/blinn_phong_shading_terms.sv
// ----------------------------------------------------------------------------
// Blinn-Phong shading terms: top level
// Fully pipelined diffuse and specular terms: one shading sample a cycle unless stalled.
// ----------------------------------------------------------------------------
// Takes one sample per clock unless stalled and returns its diffuse and
// specular RGB terms through four front stages (dot products, diffuse colour),
// sixteen stages of the bit-per-stage normalization search, one clamp
// stage, eight square-and-multiply stages for the exponent and the output
// register. The whole pipe advances together; in_stall rises only while a
// result sits in the output register and out_stall holds it. Configuration
// registers are read live, so write them only while the pipe is empty.
module blinn_phong_shading_terms #(
  parameter int VECTOR_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] light_x,
  input  logic signed [15:0] light_y,
  input  logic signed [15:0] light_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic signed [15:0] view_x,
  input  logic signed [15:0] view_y,
  input  logic signed [15:0] view_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        diffuse_red,
  output logic [15:0]        diffuse_green,
  output logic [15:0]        diffuse_blue,
  output logic [15:0]        specular_red,
  output logic [15:0]        specular_green,
  output logic [15:0]        specular_blue
);

`include "blinn_phong_shading_terms_defines.svh"

  localparam int SHL_L = (2*VECTOR_FRAC_BITS > 30) ? 2*VECTOR_FRAC_BITS - 30 : 0;
  localparam int SHL_R = (2*VECTOR_FRAC_BITS > 30) ? 0 : 30 - 2*VECTOR_FRAC_BITS;
  localparam int CW    = 70 + SHL_L + SHL_R;

  bps_pkg::rgb_t       base_col;
  bps_pkg::rgb_t       spec_col;
  logic [7:0]          shininess;
  bps_pkg::q15_t       cos_threshold;

  logic                en;
  bps_pkg::stage_ctl_t fr_ctl;
  bps_pkg::rgb_t       fr_diffuse;
  logic [CW-1:0]       fr_r;
  logic [CW-1:0]       fr_l;
  bps_pkg::stage_ctl_t nm_ctl;
  bps_pkg::rgb_t       nm_diffuse;
  logic [15:0]         nm_cos;
  bps_pkg::rgb_t       res_diffuse;
  bps_pkg::rgb_t       res_specular;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_col      <= '{red: 16'd6554, green: 16'd13107, blue: 16'd26214};
      spec_col      <= '{red: 16'd26214, green: 16'd19661, blue: 16'd6554};
      shininess     <= 8'd10;
      cos_threshold <= 16'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bps_pkg::REG_BASE_RED:      base_col.red   <= cfg_data;
        bps_pkg::REG_BASE_GREEN:    base_col.green <= cfg_data;
        bps_pkg::REG_BASE_BLUE:     base_col.blue  <= cfg_data;
        bps_pkg::REG_SPEC_RED:      spec_col.red   <= cfg_data;
        bps_pkg::REG_SPEC_GREEN:    spec_col.green <= cfg_data;
        bps_pkg::REG_SPEC_BLUE:     spec_col.blue  <= cfg_data;
        bps_pkg::REG_SHININESS:     shininess      <= cfg_data[7:0];
        bps_pkg::REG_COS_THRESHOLD: cos_threshold  <= cfg_data;
        default:                    shininess      <= shininess;
      endcase
    end
  end

  // hold the whole pipe while the output register waits
  assign in_stall = out_valid && out_stall;
  assign en       = !in_stall;

  bps_front #(.VECTOR_FRAC_BITS(VECTOR_FRAC_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (in_valid),
    .light_x       (light_x),
    .light_y       (light_y),
    .light_z       (light_z),
    .normal_x      (normal_x),
    .normal_y      (normal_y),
    .normal_z      (normal_z),
    .view_x        (view_x),
    .view_y        (view_y),
    .view_z        (view_z),
    .base_col      (base_col),
    .cos_threshold (cos_threshold),
    .ctl           (fr_ctl),
    .diffuse       (fr_diffuse),
    .r_val         (fr_r),
    .l_val         (fr_l)
  );

  bps_norm #(.VECTOR_FRAC_BITS(VECTOR_FRAC_BITS)) u_norm (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_ctl      (fr_ctl),
    .in_diffuse  (fr_diffuse),
    .r_val       (fr_r),
    .l_val       (fr_l),
    .out_ctl     (nm_ctl),
    .out_diffuse (nm_diffuse),
    .cos_raw     (nm_cos)
  );

  bps_spec u_spec (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_ctl        (nm_ctl),
    .in_diffuse    (nm_diffuse),
    .cos_raw       (nm_cos),
    .shininess     (shininess),
    .cos_threshold (cos_threshold),
    .spec_col      (spec_col),
    .out_valid     (out_valid),
    .diffuse       (res_diffuse),
    .specular      (res_specular)
  );

  assign diffuse_red    = res_diffuse.red;
  assign diffuse_green  = res_diffuse.green;
  assign diffuse_blue   = res_diffuse.blue;
  assign specular_red   = res_specular.red;
  assign specular_green = res_specular.green;
  assign specular_blue  = res_specular.blue;

  `BPS_ASSERT_NOW(a_diffuse_sat, out_valid, diffuse_red <= bps_pkg::Q15_ONE && diffuse_green <= bps_pkg::Q15_ONE && diffuse_blue <= bps_pkg::Q15_ONE)
  `BPS_ASSERT_NOW(a_specular_sat, out_valid, specular_red <= bps_pkg::Q15_ONE && specular_green <= bps_pkg::Q15_ONE && specular_blue <= bps_pkg::Q15_ONE)
  `BPS_ASSERT_NEXT(a_stall_keeps_result, in_stall, out_valid)

endmodule

// File: test/blinn_phong_shading_terms_check.sv
// ----------------------------------------------------------------------------
// Blinn-Phong shading terms: result checker
// Watches the sample and result channels and the register port. Predicts the
// diffuse and specular terms of every sample and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blinn_phong_shading_terms_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] light_x,
  input  logic signed [15:0] light_y,
  input  logic signed [15:0] light_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic signed [15:0] view_x,
  input  logic signed [15:0] view_y,
  input  logic signed [15:0] view_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        diffuse_red,
  input  logic [15:0]        diffuse_green,
  input  logic [15:0]        diffuse_blue,
  input  logic [15:0]        specular_red,
  input  logic [15:0]        specular_green,
  input  logic [15:0]        specular_blue,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);

  typedef struct packed {
    bps_pkg::rgb_t diffuse;
    bps_pkg::rgb_t specular;
  } terms_t;

  bps_pkg::q15_t base_rgb [3];
  bps_pkg::q15_t spec_rgb [3];
  logic [7:0] shine;
  bps_pkg::q15_t thresh;
  terms_t terms_q[$];

  function automatic longint unsigned clamp_one(longint unsigned x);
    return (x > 64'd32768) ? 64'd32768 : x;
  endfunction

  function automatic longint unsigned fix_mul(longint unsigned a, longint unsigned b);
    return (a * b) >> 15;
  endfunction

  function automatic terms_t shade_terms(longint lv[3], longint nv[3], longint vv[3]);
    longint hv[3];
    longint dot_i, dot_h;
    longint unsigned len2, cos_i, cos_h, pw, b, lo, hi, mid;
    logic [127:0] lhs, rhs;
    logic [7:0] e;
    terms_t t;
    dot_i = 0;
    dot_h = 0;
    len2 = 0;
    cos_h = 0;
    for (int k = 0; k < 3; k++) begin
      hv[k] = vv[k] - lv[k];
      dot_i -= lv[k] * nv[k];
      dot_h += nv[k] * hv[k];
      len2 += hv[k] * hv[k];
    end
    cos_i = (dot_i <= 0) ? 0 : clamp_one(longint'(dot_i) >> 13);
    // Negative cosine always takes the full base colour.
    if (dot_i < 0 || cos_i < thresh) cos_i = 32768;
    t.diffuse.red   = 16'(clamp_one(fix_mul(cos_i, base_rgb[0])));
    t.diffuse.green = 16'(clamp_one(fix_mul(cos_i, base_rgb[1])));
    t.diffuse.blue  = 16'(clamp_one(fix_mul(cos_i, base_rgb[2])));
    if (len2 == 0) begin
      t.specular = '0;
      return t;
    end
    if (dot_h > 0) begin
      rhs = 128'(dot_h) * 128'(dot_h);
      rhs = rhs << 30;
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        lhs = (128'(mid * mid) * 128'(len2)) << 28;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      cos_h = lo;
    end
    if (cos_h < thresh) cos_h = 0;
    pw = 32768;
    b = cos_h;
    e = shine;
    while (e != 0) begin
      if (e[0]) pw = fix_mul(pw, b);
      b = fix_mul(b, b);
      e = e >> 1;
    end
    t.specular.red   = 16'(clamp_one(fix_mul(pw, spec_rgb[0])));
    t.specular.green = 16'(clamp_one(fix_mul(pw, spec_rgb[1])));
    t.specular.blue  = 16'(clamp_one(fix_mul(pw, spec_rgb[2])));
    return t;
  endfunction

  always @(posedge clk) begin
    terms_t got, want;
    longint lv[3], nv[3], vv[3];
    if (rst) begin
      base_rgb[0] <= 16'd6554;
      base_rgb[1] <= 16'd13107;
      base_rgb[2] <= 16'd26214;
      spec_rgb[0] <= 16'd26214;
      spec_rgb[1] <= 16'd19661;
      spec_rgb[2] <= 16'd6554;
      shine <= 8'd10;
      thresh <= 16'd1;
      terms_q.delete();
      fail_count <= 0;
      checked <= 0;
      pending <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          bps_pkg::REG_BASE_RED:      base_rgb[0] <= cfg_data;
          bps_pkg::REG_BASE_GREEN:    base_rgb[1] <= cfg_data;
          bps_pkg::REG_BASE_BLUE:     base_rgb[2] <= cfg_data;
          bps_pkg::REG_SPEC_RED:      spec_rgb[0] <= cfg_data;
          bps_pkg::REG_SPEC_GREEN:    spec_rgb[1] <= cfg_data;
          bps_pkg::REG_SPEC_BLUE:     spec_rgb[2] <= cfg_data;
          bps_pkg::REG_SHININESS:     shine <= cfg_data[7:0];
          bps_pkg::REG_COS_THRESHOLD: thresh <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        lv = '{light_x, light_y, light_z};
        nv = '{normal_x, normal_y, normal_z};
        vv = '{view_x, view_y, view_z};
        terms_q.push_back(shade_terms(lv, nv, vv));
      end
      if (out_valid && !out_stall) begin
        got.diffuse  = '{diffuse_red, diffuse_green, diffuse_blue};
        got.specular = '{specular_red, specular_green, specular_blue};
        checked <= checked + 1;
        if (terms_q.size() == 0) begin
          if (fail_count < 10) $display("error: result with nothing pending: %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = terms_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display({"error: result %0d diffuse exp %0d/%0d/%0d got %0d/%0d/%0d,",
                        " specular exp %0d/%0d/%0d got %0d/%0d/%0d"},
                       checked, want.diffuse.red, want.diffuse.green, want.diffuse.blue,
                       got.diffuse.red, got.diffuse.green, got.diffuse.blue,
                       want.specular.red, want.specular.green, want.specular.blue,
                       got.specular.red, got.specular.green, got.specular.blue);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= terms_q.size();
    end
  end

endmodule

// File: test/blinn_phong_shading_terms_test.sv
// ----------------------------------------------------------------------------
// Blinn-Phong shading terms: testbench top
// Drives directed and random shading samples through several register
// settings with random gaps and stalls; the checker judges every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blinn_phong_shading_terms_test;

  localparam int LATENCY = 40;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [2:0] cfg_index = bps_pkg::REG_BASE_RED;
  logic [15:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] light_x = 0, light_y = 0, light_z = 0;
  logic signed [15:0] normal_x = 0, normal_y = 0, normal_z = 0;
  logic signed [15:0] view_x = 0, view_y = 0, view_z = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [15:0] diffuse_red, diffuse_green, diffuse_blue;
  logic [15:0] specular_red, specular_green, specular_blue;
  int fail_count, pending, checked;
  int cycles = 0;
  int sent = 0;
  bit hold_done = 0;

  blinn_phong_shading_terms dut (.*);
  blinn_phong_shading_terms_check check (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: mostly short stalls, a few long ones, one long hold-off.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (!hold_done && sent > 300) begin
        hold_done = 1;
        out_stall <= 1;
        repeat (400) @(posedge clk);
      end
      n = $urandom_range(0, 99);
      out_stall <= (n < 25);
      if (n < 3) repeat ($urandom_range(10, 40)) @(posedge clk);
      else if (n < 40) @(posedge clk);
      else repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  task automatic send_sample(input logic signed [15:0] s [9]);
    bit stalled;
    in_valid <= 1;
    {light_x, light_y, light_z} <= {s[0], s[1], s[2]};
    {normal_x, normal_y, normal_z} <= {s[3], s[4], s[5]};
    {view_x, view_y, view_z} <= {s[6], s[7], s[8]};
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    sent++;
    if ($urandom_range(0, 9) < 3) begin
      in_valid <= 0;
      if ($urandom_range(0, 19) == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] b0, b1, b2, s0, s1, s2,
                          input logic [7:0] shin, input logic [15:0] thr);
    write_reg(bps_pkg::REG_BASE_RED, b0);
    write_reg(bps_pkg::REG_BASE_GREEN, b1);
    write_reg(bps_pkg::REG_BASE_BLUE, b2);
    write_reg(bps_pkg::REG_SPEC_RED, s0);
    write_reg(bps_pkg::REG_SPEC_GREEN, s1);
    write_reg(bps_pkg::REG_SPEC_BLUE, s2);
    write_reg(bps_pkg::REG_SHININESS, {8'd0, shin});
    write_reg(bps_pkg::REG_COS_THRESHOLD, thr);
    cfg_write <= 0;
  endtask

  function automatic logic signed [15:0] jitter(int span);
    return 16'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Mostly well-formed: normal near an axis, light toward it, view nearby; some random or degenerate.
  task automatic random_samples(input int count);
    logic signed [15:0] s [9];
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      for (int k = 0; k < 3; k++) begin
        s[3 + k] = (k == 2) ? 16'($signed($urandom_range(14000, 16384))) : jitter(5000);
        if ($urandom_range(0, 1)) s[3 + k] = -s[3 + k];
        s[k] = -s[3 + k] + jitter(3000);
        s[6 + k] = s[3 + k] + jitter(8000);
      end
      if (kind < 20) foreach (s[k]) s[k] = 16'($urandom);
      else if (kind < 25) for (int k = 0; k < 3; k++) s[6 + k] = s[k];
      else if (kind < 30) for (int k = 0; k < 3; k++) s[k] = -s[k];
      send_sample(s);
    end
  endtask

  initial begin
    logic signed [15:0] s [9];
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part under reset colours.
    s = '{-16384, 0, 0, 16384, 0, 0, 16384, 0, 0}; send_sample(s);
    s = '{0, 0, -16384, 0, 0, 16384, 0, 0, 16384}; send_sample(s);
    s = '{0, 0, 16384, 0, 0, 16384, 0, 0, 16384}; send_sample(s);
    s = '{5, 7, 9, 1, 2, 3, 5, 7, 9}; send_sample(s);
    s = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_sample(s);
    s = '{-32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767}; send_sample(s);
    s = '{32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768, -32768}; send_sample(s);
    s = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    send_sample(s);
    s = '{32767, 32767, 32767, -32768, -32768, -32768, 32767, 32767, 32767}; send_sample(s);
    s = '{0, -16384, 0, 16384, 0, 0, 16384, 0, 0}; send_sample(s);
    s = '{0, 0, -16384, 0, 0, 16384, 0, 16384, 0}; send_sample(s);
    s = '{0, 0, -16384, 0, 0, 16384, 0, 0, -16384}; send_sample(s);
    s = '{-11585, 0, -11585, 0, 0, 16384, 11585, 0, 11585}; send_sample(s);
    s = '{0, 0, -1, 0, 0, 1, 0, 0, 1}; send_sample(s);
    s = '{-1, 0, 0, 8192, 0, 0, 0, 0, 0}; send_sample(s);
    s = '{-32768, 0, 0, -32768, 0, 0, 32767, 0, 0}; send_sample(s);
    random_samples(160);
    drain();

    set_regs(16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
             16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
             16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
             8'($urandom_range(1, 64)), 16'($urandom_range(0, 2000)));
    random_samples(170);
    drain();

    set_regs(16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768,
             8'd255, 16'd32768);
    random_samples(170);
    drain();

    set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
    random_samples(80);
    drain();

    set_regs(16'd32768, 16'd12345, 16'd1, 16'd32768, 16'd0, 16'd20000, 8'd1, 16'd0);
    random_samples(90);
    drain();

    set_regs(16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
             16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
             16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
             8'($urandom_range(0, 255)), 16'($urandom_range(0, 32768)));
    random_samples(170);
    drain();

    $display("Sent %0d shading samples over six register settings; %0d results checked.",
             sent, checked);
    $display("Settings covered reset colours, random, all-max, all-zero and mixed extremes.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
